@@ design/rcs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared types and constants for the ring cadence sequencer.
// ----------------------------------------------------------------------------
package rcs_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int MAX_RINGS_DEF = 8;

    localparam int STAMP_W   = 32;
    localparam int RING_W    = 4;
    localparam int PCT_W     = 7;
    localparam int MS_W      = 16;
    localparam int PHASE_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam int IN_FIELDS_W  = 2 * STAMP_W + RING_W + PCT_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + PHASE_W + 1 + RING_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [PCT_W-1:0] CUT_PERCENT = PCT_W'(70);

    localparam logic [MS_W-1:0] RING_ON_RST  = MS_W'(2000);
    localparam logic [MS_W-1:0] SHORT_RST    = MS_W'(500);
    localparam logic [MS_W-1:0] RING_OFF_RST = MS_W'(4000);
    localparam logic [MS_W-1:0] PAUSE_RST    = MS_W'(1000);

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE     = 3'd0,
        PH_RING_ON  = 3'd1,
        PH_RING_OFF = 3'd2,
        PH_PAUSE    = 3'd3,
        PH_WAITING  = 3'd4
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RING_ON  = 2'd0,
        CFG_SHORT    = 2'd1,
        CFG_RING_OFF = 2'd2,
        CFG_PAUSE    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [MS_W-1:0] ring_on_ms;
        logic [MS_W-1:0] short_ring_ms;
        logic [MS_W-1:0] ring_off_ms;
        logic [MS_W-1:0] pause_ms;
    } cfg_t;

    typedef struct packed {
        logic [RING_W-1:0] ring_number;
        logic              call_active;
        phase_t            phase;
        logic              relay_on;
    } res_t;

endpackage
`default_nettype wire

@@ design/rcs_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rcs_cfg_regs
// Timing register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module rcs_cfg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          wr_en,
    input  wire logic [rcs_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [rcs_pkg::MS_W-1:0]      wr_data,
    output rcs_pkg::cfg_t                      cfg
);
    import rcs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (cfg_idx_t'(wr_index))
                CFG_RING_ON:  cfg_next.ring_on_ms    = wr_data;
                CFG_SHORT:    cfg_next.short_ring_ms = wr_data;
                CFG_RING_OFF: cfg_next.ring_off_ms   = wr_data;
                CFG_PAUSE:    cfg_next.pause_ms      = wr_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ring_on_ms    <= RING_ON_RST;
            cfg_reg.short_ring_ms <= SHORT_RST;
            cfg_reg.ring_off_ms   <= RING_OFF_RST;
            cfg_reg.pause_ms      <= PAUSE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

@@ design/rcs_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rcs_core
// Cadence state machine: phase, timestamps and ring counters, one request per step.
// ----------------------------------------------------------------------------
module rcs_core #(
    parameter int TIME_BITS = rcs_pkg::TIME_BITS_DEF,
    parameter int MAX_RINGS = rcs_pkg::MAX_RINGS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        step,
    input  wire rcs_pkg::cfg_t               cfg,
    input  wire logic                        operation,
    input  wire logic [rcs_pkg::STAMP_W-1:0] now_ms,
    input  wire logic [rcs_pkg::STAMP_W-1:0] wait_draw_ms,
    input  wire logic [rcs_pkg::RING_W-1:0]  ring_draw,
    input  wire logic [rcs_pkg::PCT_W-1:0]   percent_draw,
    output rcs_pkg::res_t                    res
);
    import rcs_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [TIME_BITS-1:0] last_change_reg, last_change_next;
    logic [TIME_BITS-1:0] wait_len_reg, wait_len_next;
    logic [RING_W-1:0]   ring_index_reg, ring_index_next;
    logic [RING_W-1:0]   ring_total_reg, ring_total_next;
    logic                final_short_reg, final_short_next;
    logic                relay_reg, relay_next;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] wdraw_t;
    logic [TIME_BITS-1:0] elapsed;
    logic [MS_W-1:0]      on_len;
    logic                 on_done, off_done, pause_done, wait_done;
    logic                 last_ring;
    logic [RING_W-1:0]    ring_clamp;
    logic                 short_draw;
    logic                 active;

    assign now_t   = TIME_BITS'(now_ms);
    assign wdraw_t = TIME_BITS'(wait_draw_ms);
    assign elapsed = now_t - last_change_reg;

    assign on_len = (final_short_reg && (ring_index_reg == ring_total_reg))
                    ? cfg.short_ring_ms : cfg.ring_on_ms;
    assign on_done    = elapsed >= TIME_BITS'(on_len);
    assign off_done   = elapsed >= TIME_BITS'(cfg.ring_off_ms);
    assign pause_done = elapsed >= TIME_BITS'(cfg.pause_ms);
    assign wait_done  = elapsed >= wait_len_reg;
    assign last_ring  = ring_index_reg >= ring_total_reg;

    always_comb begin
        if (ring_draw == '0) begin
            ring_clamp = RING_W'(1);
        end else if (ring_draw > RING_W'(MAX_RINGS)) begin
            ring_clamp = RING_W'(MAX_RINGS);
        end else begin
            ring_clamp = ring_draw;
        end
    end

    assign short_draw = (ring_clamp > RING_W'(1)) && (percent_draw < CUT_PERCENT);

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (operation) begin
            phase_next = PH_IDLE;
        end else begin
            unique case (phase_reg)
                PH_RING_ON: begin
                    if (on_done) phase_next = last_ring ? PH_PAUSE : PH_RING_OFF;
                end
                PH_RING_OFF: begin
                    if (off_done) phase_next = PH_RING_ON;
                end
                PH_PAUSE: begin
                    if (pause_done) phase_next = PH_WAITING;
                end
                PH_WAITING: begin
                    if (wait_done) phase_next = PH_IDLE;
                end
                default: begin
                    phase_next = wait_done ? PH_RING_ON : PH_IDLE;
                end
            endcase
        end
    end

    // timestamps, counters and relay
    always_comb begin
        last_change_next = last_change_reg;
        wait_len_next    = wait_len_reg;
        ring_index_next  = ring_index_reg;
        ring_total_next  = ring_total_reg;
        final_short_next = final_short_reg;
        relay_next       = relay_reg;
        if (operation) begin
            relay_next       = 1'b0;
            wait_len_next    = wdraw_t;
            last_change_next = now_t;
        end else begin
            unique case (phase_reg)
                PH_RING_ON: begin
                    if (on_done) begin
                        relay_next       = 1'b0;
                        last_change_next = now_t;
                    end
                end
                PH_RING_OFF: begin
                    if (off_done) begin
                        ring_index_next  = ring_index_reg + RING_W'(1);
                        relay_next       = 1'b1;
                        last_change_next = now_t;
                    end
                end
                PH_PAUSE, PH_WAITING: begin
                    if ((phase_reg == PH_PAUSE) ? pause_done : wait_done) begin
                        wait_len_next    = wdraw_t;
                        last_change_next = now_t;
                    end
                end
                default: begin
                    if (wait_done) begin
                        ring_total_next  = ring_clamp;
                        ring_index_next  = RING_W'(1);
                        final_short_next = short_draw;
                        relay_next       = 1'b1;
                        last_change_next = now_t;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            last_change_reg <= '0;
            wait_len_reg    <= '0;
            ring_index_reg  <= '0;
            ring_total_reg  <= '0;
            final_short_reg <= 1'b0;
            relay_reg       <= 1'b0;
        end else if (step) begin
            phase_reg       <= phase_next;
            last_change_reg <= last_change_next;
            wait_len_reg    <= wait_len_next;
            ring_index_reg  <= ring_index_next;
            ring_total_reg  <= ring_total_next;
            final_short_reg <= final_short_next;
            relay_reg       <= relay_next;
        end
    end

    assign active = (phase_next == PH_RING_ON) || (phase_next == PH_RING_OFF) ||
                    (phase_next == PH_PAUSE);

    assign res.relay_on    = relay_next;
    assign res.phase       = phase_next;
    assign res.call_active = active;
    assign res.ring_number = active ? ring_index_next : '0;

endmodule
`default_nettype wire

@@ design/ring_cadence_sequencer_unit.sv @@
`default_nettype none
// a request is taken into the input register, then its result into the result register on m_tdata
// throughput: one request per cycle while the result register is not stalled by m_tready low
// the result register frees s_tready whenever m_tready is high or the register is empty
// reset: synchronous on aresetn low; phase idle, timestamps and counters zero, relay off
// timing registers return to 2000, 500, 4000 and 1000 ms on reset
// ----------------------------------------------------------------------------
// ring_cadence_sequencer_unit
// Telephone ring cadence sequencer with stream in/out and a register write port.
// ----------------------------------------------------------------------------
module ring_cadence_sequencer_unit #(
    parameter int TIME_BITS = rcs_pkg::TIME_BITS_DEF,
    parameter int MAX_RINGS = rcs_pkg::MAX_RINGS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // now_ms[31:0], wait_draw_ms[63:32], ring_draw[67:64], percent_draw[74:68], zero pad
    input  wire logic [rcs_pkg::IN_TDATA_W-1:0]  s_tdata,
    // operation
    input  wire logic                            s_tuser,
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    // relay_on[0], phase[3:1], call_active[4], ring_number[8:5], zero pad
    output      logic [rcs_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [rcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rcs_pkg::MS_W-1:0]        cfg_data
);
    import rcs_pkg::*;

    logic                   in_valid_reg;
    logic                   in_op_reg;
    logic [IN_TDATA_W-1:0]  in_data_reg;
    logic                   out_valid_reg;
    res_t                   out_res_reg;
    logic                   advance;
    logic                   step;
    cfg_t                   cfg;
    res_t                   res;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign step      = in_valid_reg && advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    rcs_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    rcs_core #(
        .TIME_BITS (TIME_BITS),
        .MAX_RINGS (MAX_RINGS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .cfg          (cfg),
        .operation    (in_op_reg),
        .now_ms       (in_data_reg[STAMP_W-1:0]),
        .wait_draw_ms (in_data_reg[2*STAMP_W-1:STAMP_W]),
        .ring_draw    (in_data_reg[2*STAMP_W+RING_W-1:2*STAMP_W]),
        .percent_draw (in_data_reg[IN_FIELDS_W-1:2*STAMP_W+RING_W]),
        .res          (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, out_res_reg};

endmodule
`default_nettype wire

@@ design/rcs_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rcs_checker
// Port-level checks on the result stream of the ring cadence sequencer.
// ----------------------------------------------------------------------------
module rcs_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [rcs_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import rcs_pkg::*;

    res_t r;
    assign r = m_tdata[OUT_FIELDS_W-1:0];

    // no result straight after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // call flag follows the phase
    a_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> r.call_active == ((r.phase == PH_RING_ON) ||
                                       (r.phase == PH_RING_OFF) ||
                                       (r.phase == PH_PAUSE)))
        else $error("call_active disagrees with phase");

    // relay only in a ring burst, ring number zero outside a call
    a_relay: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (r.relay_on == (r.phase == PH_RING_ON)) &&
                     (r.call_active || (r.ring_number == '0)))
        else $error("relay or ring number inconsistent");

endmodule

bind ring_cadence_sequencer_unit rcs_checker u_rcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
